/* sv/ddvc_pkg.sv */
// Shared types, widths and constants for the differential drive velocity controller.
// No dependencies; imported by every other module of the block.
package ddvc_pkg;

   localparam int MAX_SPEED_DEF     = 125;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_TABLE_LEN    = 24;

   // datapath widths
   localparam int XW  = 28;  // CORDIC x/y, covers 2^24 input plus gain growth
   localparam int ZW  = 18;  // CORDIC angle accumulator, Q5.13
   localparam int HW  = 16;  // heading converted to Q3.13
   localparam int AW  = 20;  // angle after heading subtraction

   // Q3.13 angle constants
   localparam int Q_PI      = 25736;
   localparam int Q_TWO_PI  = 51472;
   localparam int Q_HALF_PI = 12868;
   localparam int Q_DEG20   = 2860;

   localparam int HEAD_SCALE  = 51472;  // binary angle to Q3.13, divided by 2^16
   localparam int CORDIC_COMP = 39797;  // 1/K in Q16

   // configuration register map
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_VELOCITY_GAIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_GAIN    = 2'd1;
   localparam logic [15:0]          GAIN_RESET        = 16'd256;

   // per-item data that rides along the CORDIC chain
   typedef struct packed {
      logic          zero;            // error vector was zero
      logic          absolute_frame;
      logic          near_ball;
      logic [HW-1:0] head;            // heading, Q3.13
   } side_type;

   // rounded arctan(2^-i) in Q3.13
   function automatic int atan_q13(input int idx);
      int r;
      r = 0;
      case (idx)
         0:       r = 6434;
         1:       r = 3798;
         2:       r = 2007;
         3:       r = 1019;
         4:       r = 511;
         5:       r = 256;
         6:       r = 128;
         7:       r = 64;
         8:       r = 32;
         9:       r = 16;
         10:      r = 8;
         11:      r = 4;
         12:      r = 2;
         13:      r = 1;
         default: r = 0;
      endcase
      return r;
   endfunction

endpackage

/* sv/ddvc_front.sv */
// Front end: error vector, heading conversion and CORDIC pre-rotation, two register stages.
// Depends on ddvc_pkg.
module ddvc_front
   import ddvc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [15:0]   target_vel_x,
   input  logic signed [15:0]   target_vel_y,
   input  logic signed [15:0]   measured_vel_x,
   input  logic signed [15:0]   measured_vel_y,
   input  logic [15:0]          heading,
   input  logic                 absolute_frame,
   input  logic                 near_ball,
   output logic                 out_valid,
   output logic signed [XW-1:0] out_x,
   output logic signed [XW-1:0] out_y,
   output logic signed [ZW-1:0] out_z,
   output side_type             out_side
);

   localparam logic [31:0] HEAD_ROUND = 32'd32768;

   // stage 1
   logic               v1_ff;
   logic signed [16:0] dx_ff, dx_in;
   logic signed [16:0] dy_ff, dy_in;
   logic [31:0]        hprod_ff, hprod_in;
   logic               abs1_ff, near1_ff;

   // stage 2
   logic               v2_ff;
   logic signed [XW-1:0] x_ff, x_in;
   logic signed [XW-1:0] y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   side_type           side_ff, side_in;
   logic [31:0]        hsum;
   logic signed [XW-1:0] xs, ys;

   always_comb begin
      dx_in    = {target_vel_x[15], target_vel_x} - {measured_vel_x[15], measured_vel_x};
      dy_in    = {target_vel_y[15], target_vel_y} - {measured_vel_y[15], measured_vel_y};
      hprod_in = 32'(heading) * 32'(HEAD_SCALE);
   end

   always_comb begin
      xs = {{(XW-25){dx_ff[16]}}, dx_ff, 8'b0};
      ys = {{(XW-25){dy_ff[16]}}, dy_ff, 8'b0};
      hsum = hprod_ff + HEAD_ROUND;
      // left half plane: turn by pi first
      if (dx_ff[16]) begin
         x_in = -xs;
         y_in = -ys;
         z_in = dy_ff[16] ? -ZW'(Q_PI) : ZW'(Q_PI);
      end else begin
         x_in = xs;
         y_in = ys;
         z_in = '0;
      end
      side_in.zero           = (dx_ff == '0) && (dy_ff == '0);
      side_in.absolute_frame = abs1_ff;
      side_in.near_ball      = near1_ff;
      side_in.head           = hsum[31:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      hprod_ff <= hprod_in;
      abs1_ff  <= absolute_frame;
      near1_ff <= near_ball;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      side_ff  <= side_in;
   end

   assign out_valid = v2_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

/* sv/ddvc_cordic_stage.sv */
// One registered CORDIC vectoring iteration (shift by SHIFT, table angle step).
// Depends on ddvc_pkg.
module ddvc_cordic_stage
   import ddvc_pkg::*;
#(
   parameter int SHIFT = 0
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [XW-1:0] in_x,
   input  logic signed [XW-1:0] in_y,
   input  logic signed [ZW-1:0] in_z,
   input  side_type             in_side,
   output logic                 out_valid,
   output logic signed [XW-1:0] out_x,
   output logic signed [XW-1:0] out_y,
   output logic signed [ZW-1:0] out_z,
   output side_type             out_side
);

   localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q13(SHIFT));

   logic                 valid_ff;
   logic signed [XW-1:0] x_ff, x_in;
   logic signed [XW-1:0] y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   side_type             side_ff;

   always_comb begin
      // y of zero counts as the positive side
      if (!in_y[XW-1]) begin
         x_in = in_x + (in_y >>> SHIFT);
         y_in = in_y - (in_x >>> SHIFT);
         z_in = in_z + ATAN;
      end else begin
         x_in = in_x - (in_y >>> SHIFT);
         y_in = in_y + (in_x >>> SHIFT);
         z_in = in_z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

/* sv/ddvc_steer.sv */
// Back end: magnitude scaling, heading and half-turn correction, gain products,
// forward cap and saturation, seven register stages. Depends on ddvc_pkg.
module ddvc_steer
   import ddvc_pkg::*;
#(
   parameter int MAX_SPEED = MAX_SPEED_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [XW-1:0] in_x,
   input  logic signed [ZW-1:0] in_z,
   input  side_type             in_side,
   input  logic [15:0]          velocity_gain,
   input  logic [15:0]          angle_gain,
   output logic                 out_valid,
   output logic signed [15:0]   left_speed,
   output logic signed [15:0]   right_speed
);

   localparam int MW = 19;   // signed magnitude
   localparam int VW = 28;   // rounded forward term
   localparam int TW = 12;   // rounded turn term

   localparam logic [42:0]          MAG_ROUND  = 43'd1 << 23;
   localparam logic signed [32:0]   TURN_ROUND = 33'sd1 <<< 20;
   localparam logic signed [35:0]   VEL_ROUND  = 36'sd128;
   localparam logic signed [VW:0]   MAX_Q      = (VW+1)'(MAX_SPEED);
   localparam logic signed [AW-1:0] PI_A       = AW'(Q_PI);
   localparam logic signed [AW-1:0] TWO_PI_A   = AW'(Q_TWO_PI);
   localparam logic signed [AW-1:0] HALF_PI_A  = AW'(Q_HALF_PI);
   localparam logic signed [15:0]   DEG20_A    = 16'(Q_DEG20);

   function automatic logic signed [AW-1:0] wrap(input logic signed [AW-1:0] a);
      logic signed [AW-1:0] r;
      r = a;
      for (int k = 0; k < 2; k++) begin
         if (r > PI_A) begin
            r = r - TWO_PI_A;
         end else if (r < -PI_A) begin
            r = r + TWO_PI_A;
         end
      end
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [VW+1:0] v);
      logic signed [15:0] r;
      if (v > (VW+2)'(32767)) begin
         r = 16'sh7FFF;
      end else if (v < -(VW+2)'(32768)) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic signed [VW-1:0] fwd5_in_gate(input logic f,
                                                          input logic signed [VW-1:0] v);
      return f ? v : '0;
   endfunction

   logic [6:0] valid_ff;

   // s1
   logic [42:0]          mprod_ff, mprod_in;
   logic signed [AW-1:0] ang1_ff, ang1_in;
   logic                 zero1_ff, near1_ff;
   // s2
   logic signed [MW-1:0] mag2_ff, mag2_in;
   logic signed [AW-1:0] ang2_ff, ang2_in;
   logic                 near2_ff;
   logic [42:0]          msum;
   // s3
   logic signed [MW-1:0] mag3_ff, mag3_in;
   logic signed [15:0]   ang3_ff, ang3_in;
   logic                 fwd3_ff, fwd3_in;
   logic                 behind;
   logic signed [AW-1:0] flipped;
   // s4
   logic signed [32:0]   tprod_ff, tprod_in;
   logic signed [35:0]   vprod_ff, vprod_in;
   logic                 fwd4_ff;
   // s5
   logic signed [TW-1:0] turn5_ff, turn5_in;
   logic [TW-1:0]        aturn5_ff, aturn5_in;
   logic signed [VW-1:0] vel5_ff, vel5_in;
   logic                 fwd5_ff;
   logic signed [32:0]   tsum;
   logic signed [35:0]   vsum;
   // s6
   logic signed [VW:0]   vel6_ff, vel6_in;
   logic signed [TW-1:0] turn6_ff;
   logic signed [VW:0]   capsum;
   // s7
   logic signed [15:0]   left_ff, left_in;
   logic signed [15:0]   right_ff, right_in;

   always_comb begin
      // s1: magnitude product, heading subtraction; zero vector gives CORDIC angle 0
      mprod_in = 43'(in_x[XW-2:0]) * 43'(CORDIC_COMP);
      ang1_in  = (in_side.zero ? '0 : AW'(in_z))
               - (in_side.absolute_frame ? AW'({1'b0, in_side.head}) : '0);

      // s2
      msum    = mprod_ff + MAG_ROUND;
      mag2_in = zero1_ff ? '0 : $signed(msum[24+MW-1:24]);
      ang2_in = wrap(ang1_ff);

      // s3: error behind the robot turns half a revolution, drives backwards
      behind  = (ang2_ff > HALF_PI_A) || (ang2_ff < -HALF_PI_A);
      flipped = wrap(ang2_ff + PI_A);
      if (behind) begin
         mag3_in = -mag2_ff;
         ang3_in = flipped[15:0];
      end else begin
         mag3_in = mag2_ff;
         ang3_in = ang2_ff[15:0];
      end
      fwd3_in = ((ang3_in < DEG20_A) && (ang3_in > -DEG20_A)) || near2_ff;

      // s4
      tprod_in = 33'(ang3_ff) * $signed({17'b0, angle_gain});
      vprod_in = 36'(mag3_ff) * $signed({20'b0, velocity_gain});

      // s5: round half up, absolute turn, forward term zeroed unless forward flag set
      tsum      = tprod_ff + TURN_ROUND;
      turn5_in  = tsum[32:21];
      aturn5_in = turn5_in[TW-1] ? TW'(-turn5_in) : TW'(turn5_in);
      vsum      = vprod_ff + VEL_ROUND;
      vel5_in   = fwd5_in_gate(fwd4_ff, vsum[35:8]);

      // s6: cap the forward term so forward plus turn stays within the limit
      capsum  = (VW+1)'(vel5_ff) + $signed({{(VW+1-TW){1'b0}}, aturn5_ff});
      if (fwd5_ff && (capsum > MAX_Q)) begin
         vel6_in = MAX_Q - $signed({{(VW+1-TW){1'b0}}, aturn5_ff});
      end else begin
         vel6_in = (VW+1)'(vel5_ff);
      end

      // s7
      left_in  = sat16((VW+2)'(vel6_ff) - (VW+2)'(turn6_ff));
      right_in = sat16((VW+2)'(vel6_ff) + (VW+2)'(turn6_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[5:0], in_valid};
      end
      mprod_ff  <= mprod_in;
      ang1_ff   <= ang1_in;
      zero1_ff  <= in_side.zero;
      near1_ff  <= in_side.near_ball;
      mag2_ff   <= mag2_in;
      ang2_ff   <= ang2_in;
      near2_ff  <= near1_ff;
      mag3_ff   <= mag3_in;
      ang3_ff   <= ang3_in;
      fwd3_ff   <= fwd3_in;
      tprod_ff  <= tprod_in;
      vprod_ff  <= vprod_in;
      fwd4_ff   <= fwd3_ff;
      turn5_ff  <= turn5_in;
      aturn5_ff <= aturn5_in;
      vel5_ff   <= vel5_in;
      fwd5_ff   <= fwd4_ff;
      vel6_ff   <= vel6_in;
      turn6_ff  <= turn5_ff;
      left_ff   <= left_in;
      right_ff  <= right_in;
   end

   assign out_valid   = valid_ff[6];
   assign left_speed  = left_ff;
   assign right_speed = right_ff;

endmodule

/* sv/diff_drive_velocity_controller_core.sv */
// Top level of the differential drive velocity controller: gain registers,
// front end, CORDIC chain and steering back end. Depends on ddvc_pkg and all ddvc_ modules.
//
// Usage
//   Request channel: drive the req_ fields and raise start. A request is taken at
//   every rising edge with start high and busy low; busy is never raised, so one
//   request may enter on every clock cycle.
//   Result channel: rsp_valid is high for exactly one cycle per request, with
//   rsp_left_speed and rsp_right_speed valid in that cycle. Results leave in
//   request order. The receiver has no way to hold them back and must take
//   every strobe.
//   Pipeline: two front-end stages, one register per CORDIC iteration and seven
//   back-end stages lie between the accepting edge and the result strobe.
//   Throughput is one request per cycle.
//   Configuration: csr_valid/csr_ready write channel, always ready. Index 0 is
//   the velocity gain, index 1 the angle gain (both unsigned Q8.8); other
//   indices are dropped. Write the gains only while no request is in flight.
//   Reset (synchronous, active high) empties the pipeline and loads both gains
//   with 1.0 (256).
module diff_drive_velocity_controller_core
   import ddvc_pkg::*;
#(
   parameter int MAX_SPEED     = MAX_SPEED_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   // request
   input  logic                 start,
   output logic                 busy,
   input  logic signed [15:0]   req_target_vel_x,
   input  logic signed [15:0]   req_target_vel_y,
   input  logic signed [15:0]   req_measured_vel_x,
   input  logic signed [15:0]   req_measured_vel_y,
   input  logic [15:0]          req_heading,
   input  logic                 req_absolute_frame,
   input  logic                 req_near_ball,
   // result
   output logic                 rsp_valid,
   output logic signed [15:0]   rsp_left_speed,
   output logic signed [15:0]   rsp_right_speed,
   // configuration
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata
);

   logic [15:0] vel_gain_ff;
   logic [15:0] ang_gain_ff;
   logic        accept;

   logic                 cv [CORDIC_STAGES+1];
   logic signed [XW-1:0] cx [CORDIC_STAGES+1];
   logic signed [XW-1:0] cy [CORDIC_STAGES+1];
   logic signed [ZW-1:0] cz [CORDIC_STAGES+1];
   side_type             cs [CORDIC_STAGES+1];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_gain_ff <= GAIN_RESET;
         ang_gain_ff <= GAIN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VELOCITY_GAIN: vel_gain_ff <= csr_wdata;
            CSR_ANGLE_GAIN:    ang_gain_ff <= csr_wdata;
            default:           ;
         endcase
      end
   end

   ddvc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (accept),
      .target_vel_x   (req_target_vel_x),
      .target_vel_y   (req_target_vel_y),
      .measured_vel_x (req_measured_vel_x),
      .measured_vel_y (req_measured_vel_y),
      .heading        (req_heading),
      .absolute_frame (req_absolute_frame),
      .near_ball      (req_near_ball),
      .out_valid      (cv[0]),
      .out_x          (cx[0]),
      .out_y          (cy[0]),
      .out_z          (cz[0]),
      .out_side       (cs[0])
   );

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      ddvc_cordic_stage #(
         .SHIFT (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[i]),
         .in_x      (cx[i]),
         .in_y      (cy[i]),
         .in_z      (cz[i]),
         .in_side   (cs[i]),
         .out_valid (cv[i+1]),
         .out_x     (cx[i+1]),
         .out_y     (cy[i+1]),
         .out_z     (cz[i+1]),
         .out_side  (cs[i+1])
      );
   end

   ddvc_steer #(
      .MAX_SPEED (MAX_SPEED)
   ) u_steer (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (cv[CORDIC_STAGES]),
      .in_x          (cx[CORDIC_STAGES]),
      .in_z          (cz[CORDIC_STAGES]),
      .in_side       (cs[CORDIC_STAGES]),
      .velocity_gain (vel_gain_ff),
      .angle_gain    (ang_gain_ff),
      .out_valid     (rsp_valid),
      .left_speed    (rsp_left_speed),
      .right_speed   (rsp_right_speed)
   );

endmodule
